// ----- sv/aik_pkg.sv -----
// Shared constants, types and helper functions for the arm inverse kinematics block.
// Used by the root and CORDIC cell rows and by the top level; depends on nothing.
package aik_pkg;

    // Algorithm sizes
    localparam int CORDIC_STEPS    = 16;
    localparam int CORDIC_LAT      = CORDIC_STEPS + 1;
    localparam int LEN_FRAC        = 8;
    localparam int ANG_FRAC        = 16;
    localparam int CORDIC_PRESCALE = 24;

    // Datapath widths
    localparam int COORD_W  = 17;
    localparam int LEN_W    = 16;
    localparam int SH_W     = COORD_W + 2;
    localparam int SQ_W     = 56;
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int SQ_IDX_W = $clog2(SQ_STEPS);
    localparam int R_W      = SQ_STEPS;
    localparam int F_W      = R_W + 2;
    localparam int CI_W     = R_W + 1;
    localparam int C_W      = 56;
    localparam int Z_W      = 28;
    localparam int A_W      = 32;
    localparam int AT_W     = 22;
    localparam int AT_DEPTH = 32;
    localparam int AT_IDX_W = $clog2(AT_DEPTH);

    // Ports
    localparam int BASE_W    = 17;
    localparam int ANG_W     = 18;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);

    // Angle constants in 1/65536 degree, limits in 1/256 degree
    localparam logic signed [A_W-1:0] D90        = A_W'(90 << ANG_FRAC);
    localparam logic signed [Z_W-1:0] Z180       = Z_W'(180 << ANG_FRAC);
    localparam logic signed [A_W-1:0] BASE_LIMIT  = A_W'(46080);
    localparam logic signed [A_W-1:0] ANGLE_LIMIT = A_W'(92160);
    localparam logic [LEN_W-1:0]      LINK_RESET  = LEN_W'(1600);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UPPER_ARM,
        REG_FOREARM,
        REG_WRIST_DROP,
        REG_SHOULDER_H,
        REG_SHOULDER_FWD,
        REG_GRIP_FWD,
        REG_GRIP_SIDE,
        REG_GRIP_H
    } t_reg_idx;

    // Arctangent of 2^-i in 1/65536 degree
    localparam logic [AT_W-1:0] ATAN_TAB [AT_DEPTH] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0,
        22'd0,       22'd0,       22'd0,      22'd0
    };

    // State handed between root cells
    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
    } t_sqrt;

    // State handed between CORDIC cells
    typedef struct packed {
        logic [C_W-1:0] a;
        logic [C_W-1:0] b;
        logic [Z_W-1:0] z;
        logic           zero;
    } t_cordic;

    // Trial bit of the root digit handled by one cell
    function automatic logic [SQ_W-1:0] sq_bit(input logic [SQ_IDX_W-1:0] step);
        return SQ_W'(1) << (2 * (SQ_STEPS - 1 - int'(step)));
    endfunction

    // Round half up to 1/256 degree and saturate
    function automatic logic signed [A_W-1:0] to_out(input logic signed [A_W-1:0] v,
                                                     input logic signed [A_W-1:0] lim);
        logic signed [A_W-1:0] r;
        r = (v + A_W'(1 << (ANG_FRAC - 9))) >>> (ANG_FRAC - 8);
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

// ----- sv/aik_sqrt_cell.sv -----
// One digit of the restoring square root: compare, subtract and shift.
// Depends on aik_pkg for the cell state type and the trial bit function.
module aik_sqrt_cell (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [aik_pkg::SQ_IDX_W-1:0]   i_step,
    input  aik_pkg::t_sqrt                 i_d,
    output aik_pkg::t_sqrt                 o_q
);
    import aik_pkg::*;

    logic [SQ_W-1:0] bitv;
    logic [SQ_W:0]   trial;
    t_sqrt           n_q;
    t_sqrt           r_q;

    // Try this digit; keep it when the remainder covers the trial value
    always_comb begin
        bitv  = sq_bit(i_step);
        trial = {1'b0, i_d.res} + {1'b0, bitv};
        if ({1'b0, i_d.rem} >= trial) begin
            n_q.rem = i_d.rem - trial[SQ_W-1:0];
            n_q.res = (i_d.res >> 1) + bitv;
        end else begin
            n_q.rem = i_d.rem;
            n_q.res = i_d.res >> 1;
        end
    end

    // Hand the state on
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ----- sv/aik_sqrt.sv -----
// Floor square root as a row of digit cells, one digit per cell per cycle while i_en is high.
// Depends on aik_pkg and aik_sqrt_cell.
module aik_sqrt (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [aik_pkg::SQ_W-1:0] i_rad,
    output logic [aik_pkg::R_W-1:0]  o_root
);
    import aik_pkg::*;

    t_sqrt chain [SQ_STEPS+1];

    assign chain[0] = '{rem: i_rad, res: '0};

    // Row of digit cells, most significant digit first
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_cell
        aik_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_step (SQ_IDX_W'(k)),
            .i_d    (chain[k]),
            .o_q    (chain[k+1])
        );
    end

    assign o_root = chain[SQ_STEPS].res[R_W-1:0];

endmodule

// ----- sv/aik_cordic_cell.sv -----
// One micro-rotation of circular CORDIC vectoring.
// Depends on aik_pkg for the cell state type and the arctangent table.
module aik_cordic_cell (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [aik_pkg::AT_IDX_W-1:0] i_step,
    input  aik_pkg::t_cordic             i_d,
    output aik_pkg::t_cordic             o_q
);
    import aik_pkg::*;

    logic signed [C_W-1:0] a;
    logic signed [C_W-1:0] b;
    logic signed [C_W-1:0] da;
    logic signed [C_W-1:0] db;
    logic signed [Z_W-1:0] z;
    logic signed [Z_W-1:0] at;
    t_cordic               n_q;
    t_cordic               r_q;

    // Rotate towards the x axis and book the angle
    always_comb begin
        a  = i_d.a;
        b  = i_d.b;
        z  = i_d.z;
        da = b >>> i_step;
        db = a >>> i_step;
        at = $signed({{(Z_W - AT_W){1'b0}}, ATAN_TAB[i_step]});
        n_q.zero = i_d.zero;
        if (!b[C_W-1]) begin
            n_q.a = a + da;
            n_q.b = b - db;
            n_q.z = i_d.zero ? z : z + at;
        end else begin
            n_q.a = a - da;
            n_q.b = b + db;
            n_q.z = i_d.zero ? z : z - at;
        end
    end

    // Hand the state on
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ----- sv/aik_cordic.sv -----
// Angle of a vector (a, b) by CORDIC vectoring: one prescale stage, then a row of cells.
// Depends on aik_pkg and aik_cordic_cell.
module aik_cordic (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [aik_pkg::CI_W-1:0] i_b,
    input  logic signed [aik_pkg::CI_W-1:0] i_a,
    output logic signed [aik_pkg::Z_W-1:0]  o_z
);
    import aik_pkg::*;

    logic signed [C_W-1:0] a0;
    logic signed [C_W-1:0] b0;
    t_cordic               n_prep;
    t_cordic               r_prep;
    t_cordic               chain [CORDIC_STEPS+1];

    // Prescale, flag the zero vector and fold the left half plane over
    always_comb begin
        a0 = C_W'(i_a) <<< CORDIC_PRESCALE;
        b0 = C_W'(i_b) <<< CORDIC_PRESCALE;
        n_prep.zero = (i_a == '0) && (i_b == '0);
        if (a0[C_W-1]) begin
            n_prep.z = b0[C_W-1] ? -Z180 : Z180;
            n_prep.a = -a0;
            n_prep.b = -b0;
        end else begin
            n_prep.z = '0;
            n_prep.a = a0;
            n_prep.b = b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep <= n_prep;
        end
    end

    assign chain[0] = r_prep;

    // Row of micro-rotation cells
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        aik_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_step (AT_IDX_W'(k)),
            .i_d    (chain[k]),
            .o_q    (chain[k+1])
        );
    end

    assign o_z = chain[CORDIC_STEPS].z;

endmodule

// ----- sv/arm_inverse_kinematics.sv -----
// Top level of the three-link arm inverse kinematics pipeline.
// Depends on aik_pkg, aik_sqrt (with aik_sqrt_cell) and aik_cordic (with aik_cordic_cell).
//
// Usage:
//   Targets (x, y, z, 1/16 mm) enter on the i_s_* stream; one result per target leaves
//   on the o_m_* stream: base, shoulder, elbow and wrist angles in 1/256 degree in
//   o_m_tdata and the reachable flag in o_m_tuser. An unreachable target gives all
//   angles zero with the flag low.
//   Link lengths and offsets are written through i_cfg_we / i_cfg_addr / i_cfg_wdata
//   while no target is in flight.
//   Past the accepting edge a target runs through a two-stage front end, three rows of
//   28 square root cells with offset, bound, factor and product stages between them, a
//   row of 17 CORDIC stages (prescale plus 16 micro-rotations) and two stages of angle
//   sums. One target per cycle, all rows advancing together, while o_s_tready is high.
//   The result leaves through an output register backed by a skid register, so the
//   pipeline keeps accepting while one result waits; with both full, o_s_tready drops
//   and the whole pipeline holds until the receiver takes a result.
//   Reset clears all valid flags and loads the register defaults (both links 1600,
//   everything else 0); no clearing pass is needed.
module arm_inverse_kinematics (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // target_x [16:0], target_y [33:17], target_z [50:34], zero [55:51]
    input  logic [aik_pkg::S_TDATA_W-1:0]     i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // base_angle [16:0], shoulder_angle [34:17], elbow_angle [52:35],
    // wrist_angle [70:53], zero [71]
    output logic [aik_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // reachable [0]
    output logic                              o_m_tuser,
    input  logic                              i_cfg_we,
    input  logic [aik_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [aik_pkg::LEN_W-1:0]         i_cfg_wdata
);
    import aik_pkg::*;

    typedef struct packed {
        logic               vld;
        logic               reach;
        logic               shpos;
        logic [R_W-1:0]     ash;
        logic [R_W-1:0]     w;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_side;

    typedef struct packed {
        logic                  vld;
        logic                  reach;
        logic signed [A_W-1:0] base;
        logic signed [A_W-1:0] sho;
        logic signed [A_W-1:0] e;
    } t_sums;

    typedef struct packed {
        logic              reach;
        logic [ANG_W-1:0]  wri;
        logic [ANG_W-1:0]  elb;
        logic [ANG_W-1:0]  sho;
        logic [BASE_W-1:0] base;
    } t_result;

    logic en;

    // ------------------------------------------------------------------
    // Configuration registers
    logic [LEN_W-1:0] r_cfg [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= '0;
            end
            r_cfg[REG_UPPER_ARM] <= LINK_RESET;
            r_cfg[REG_FOREARM]   <= LINK_RESET;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    logic                      r_s0_vld;
    logic signed [COORD_W-1:0] r_s0_x;
    logic signed [COORD_W-1:0] r_s0_y;
    logic signed [COORD_W-1:0] r_s0_z;

    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_x <= i_s_tdata[COORD_W-1:0];
            r_s0_y <= i_s_tdata[2*COORD_W-1:COORD_W];
            r_s0_z <= i_s_tdata[3*COORD_W-1:2*COORD_W];
        end
    end

    // ------------------------------------------------------------------
    // Squared planar reach and relative height
    logic signed [2*COORD_W-1:0] xx;
    logic signed [2*COORD_W-1:0] yy;
    logic signed [LEN_W-1:0]     side;
    logic signed [2*LEN_W-1:0]   ss;
    logic [2*COORD_W:0]          sumsq;
    logic signed [SH_W-1:0]      sh;
    logic [SH_W-2:0]             sh_mag;
    logic [SQ_W-1:0]             n_s1_sq;
    t_side                       n_s1;
    logic [SQ_W-1:0]             r_s1_sq;
    t_side                       r_s1;

    always_comb begin
        side  = r_cfg[REG_GRIP_SIDE];
        xx    = r_s0_x * r_s0_x;
        yy    = r_s0_y * r_s0_y;
        ss    = side * side;
        sumsq = (2*COORD_W+1)'(unsigned'(xx)) + (2*COORD_W+1)'(unsigned'(yy))
              + (2*COORD_W+1)'(unsigned'(ss));
        n_s1_sq = SQ_W'(sumsq) << (2 * LEN_FRAC);
        sh = SH_W'(r_s0_z) + SH_W'(r_cfg[REG_WRIST_DROP]) + SH_W'(r_cfg[REG_GRIP_H])
           - SH_W'(r_cfg[REG_SHOULDER_H]);
        sh_mag = sh[SH_W-1] ? (SH_W-1)'(-sh) : sh[SH_W-2:0];
        n_s1.vld   = r_s0_vld;
        n_s1.reach = 1'b0;
        n_s1.shpos = !sh[SH_W-1] && (sh != '0);
        n_s1.ash   = R_W'(sh_mag) << LEN_FRAC;
        n_s1.w     = '0;
        n_s1.x     = r_s0_x;
        n_s1.y     = r_s0_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else if (en) begin
            r_s1 <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sq <= n_s1_sq;
        end
    end

    // ------------------------------------------------------------------
    // Radial reach root, side data delayed alongside
    logic [R_W-1:0] root_w;
    t_side          r_dlw [SQ_STEPS];

    aik_sqrt u_sqrt_w (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_s1_sq),
        .o_root (root_w)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_dlw[k].vld <= 1'b0;
            end
        end else if (en) begin
            r_dlw[0] <= r_s1;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_dlw[k] <= r_dlw[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Subtract forward offsets, clamp at zero
    logic [LEN_W:0]          off_sum;
    logic signed [R_W:0]     off;
    logic signed [R_W:0]     wdiff;
    t_side                   n_s2;
    t_side                   r_s2;

    always_comb begin
        off_sum = {1'b0, r_cfg[REG_SHOULDER_FWD]} + {1'b0, r_cfg[REG_GRIP_FWD]};
        off     = (R_W+1)'(off_sum) << LEN_FRAC;
        wdiff   = $signed({1'b0, root_w}) - off;
        n_s2    = r_dlw[SQ_STEPS-1];
        n_s2.w  = wdiff[R_W] ? '0 : wdiff[R_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end else if (en) begin
            r_s2 <= n_s2;
        end
    end

    // ------------------------------------------------------------------
    // Squared distance and squared link bounds
    logic [2*R_W-1:0] wsq;
    logic [2*R_W-1:0] asq;
    logic [R_W-1:0]   lsum;
    logic [R_W-1:0]   ldif;
    logic [LEN_W-1:0] ldif_raw;
    logic [2*R_W-1:0] n_lsq;
    logic [2*R_W-1:0] n_dsq;
    logic [SQ_W-1:0]  r_s3_hsq;
    logic [SQ_W-1:0]  r_lsq;
    logic [SQ_W-1:0]  r_dsq;
    t_side            r_s3;

    always_comb begin
        wsq  = r_s2.w * r_s2.w;
        asq  = r_s2.ash * r_s2.ash;
        lsum = R_W'({1'b0, r_cfg[REG_UPPER_ARM]} + {1'b0, r_cfg[REG_FOREARM]}) << LEN_FRAC;
        ldif_raw = (r_cfg[REG_UPPER_ARM] >= r_cfg[REG_FOREARM])
                 ? r_cfg[REG_UPPER_ARM] - r_cfg[REG_FOREARM]
                 : r_cfg[REG_FOREARM] - r_cfg[REG_UPPER_ARM];
        ldif  = R_W'(ldif_raw) << LEN_FRAC;
        n_lsq = lsum * lsum;
        n_dsq = ldif * ldif;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.vld <= 1'b0;
        end else if (en) begin
            r_s3 <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_hsq <= SQ_W'(wsq + asq);
            r_lsq    <= SQ_W'(n_lsq);
            r_dsq    <= SQ_W'(n_dsq);
        end
    end

    // ------------------------------------------------------------------
    // Distance root; reach test travels with the side data
    logic [R_W-1:0] root_h;
    t_side          n_h0;
    t_side          r_dlh [SQ_STEPS];

    aik_sqrt u_sqrt_h (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_s3_hsq),
        .o_root (root_h)
    );

    always_comb begin
        n_h0       = r_s3;
        n_h0.reach = !((r_s3_hsq > r_lsq) || (r_s3_hsq < r_dsq));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_dlh[k].vld <= 1'b0;
            end
        end else if (en) begin
            r_dlh[0] <= n_h0;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_dlh[k] <= r_dlh[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Law of cosines factors, clamped at zero
    logic signed [F_W-1:0] hh;
    logic signed [F_W-1:0] l1;
    logic signed [F_W-1:0] l2;
    logic signed [F_W-1:0] f [8];
    logic [R_W-1:0]        n_fac [8];
    logic [R_W-1:0]        r_fac [8];
    t_side                 r_s4;

    always_comb begin
        hh   = $signed({2'b0, root_h});
        l1   = F_W'(r_cfg[REG_UPPER_ARM]) << LEN_FRAC;
        l2   = F_W'(r_cfg[REG_FOREARM]) << LEN_FRAC;
        f[0] = l2 - l1 + hh;
        f[1] = l1 + l2 - hh;
        f[2] = l1 + hh - l2;
        f[3] = l1 + hh + l2;
        f[4] = hh - l1 + l2;
        f[5] = hh + l1 - l2;
        f[6] = l1 + l2 - hh;
        f[7] = l1 + l2 + hh;
        for (int k = 0; k < 8; k++) begin
            n_fac[k] = f[k][F_W-1] ? '0 : f[k][R_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.vld <= 1'b0;
        end else if (en) begin
            r_s4 <= r_dlh[SQ_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fac <= n_fac;
        end
    end

    // ------------------------------------------------------------------
    // Factor products
    logic [SQ_W-1:0] r_prod [4];
    t_side           r_s5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5.vld <= 1'b0;
        end else if (en) begin
            r_s5 <= r_s4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                r_prod[j] <= r_fac[2*j] * r_fac[2*j+1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Half-angle roots
    logic [R_W-1:0] root_p [4];
    t_side          r_dlr [SQ_STEPS];

    for (genvar j = 0; j < 4; j++) begin : g_sqrt_p
        aik_sqrt u_sqrt_p (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rad  (r_prod[j]),
            .o_root (root_p[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_dlr[k].vld <= 1'b0;
            end
        end else if (en) begin
            r_dlr[0] <= r_s5;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_dlr[k] <= r_dlr[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Four angles in parallel: half shoulder, tilt, half elbow and base
    t_side                 sd;
    logic signed [Z_W-1:0] z_a;
    logic signed [Z_W-1:0] z_b;
    logic signed [Z_W-1:0] z_e;
    logic signed [Z_W-1:0] z_base;
    t_side                 r_dlc [CORDIC_LAT];

    assign sd = r_dlr[SQ_STEPS-1];

    aik_cordic u_cordic_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_b   ($signed({1'b0, root_p[0]})),
        .i_a   ($signed({1'b0, root_p[1]})),
        .o_z   (z_a)
    );

    aik_cordic u_cordic_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_b   ($signed({1'b0, sd.ash})),
        .i_a   ($signed({1'b0, sd.w})),
        .o_z   (z_b)
    );

    aik_cordic u_cordic_e (
        .i_clk (i_clk),
        .i_en  (en),
        .i_b   ($signed({1'b0, root_p[2]})),
        .i_a   ($signed({1'b0, root_p[3]})),
        .o_z   (z_e)
    );

    aik_cordic u_cordic_base (
        .i_clk (i_clk),
        .i_en  (en),
        .i_b   (CI_W'($signed(sd.x))),
        .i_a   (CI_W'($signed(sd.y))),
        .o_z   (z_base)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORDIC_LAT; k++) begin
                r_dlc[k].vld <= 1'b0;
            end
        end else if (en) begin
            r_dlc[0] <= sd;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_dlc[k] <= r_dlc[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Shoulder angle and doubled elbow half-angle
    logic signed [A_W-1:0] ra;
    logic signed [A_W-1:0] rb;
    t_sums                 n_c1;
    t_sums                 r_c1;

    always_comb begin
        ra         = A_W'(z_a) <<< 1;
        rb         = A_W'(z_b);
        n_c1.vld   = r_dlc[CORDIC_LAT-1].vld;
        n_c1.reach = r_dlc[CORDIC_LAT-1].reach;
        n_c1.base  = A_W'(z_base);
        n_c1.sho   = r_dlc[CORDIC_LAT-1].shpos ? D90 - (ra + rb) : D90 - (ra - rb);
        n_c1.e     = A_W'(z_e) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.vld <= 1'b0;
        end else if (en) begin
            r_c1 <= n_c1;
        end
    end

    // ------------------------------------------------------------------
    // Elbow and wrist, round, saturate, zero when out of reach
    logic signed [A_W-1:0] elb;
    logic signed [A_W-1:0] wri;
    logic signed [A_W-1:0] o_base;
    logic signed [A_W-1:0] o_sho;
    logic signed [A_W-1:0] o_elb;
    logic signed [A_W-1:0] o_wri;
    t_result               n_res;

    always_comb begin
        elb    = D90 - r_c1.e;
        wri    = r_c1.e - r_c1.sho - D90;
        o_base = to_out(r_c1.base, BASE_LIMIT);
        o_sho  = to_out(r_c1.sho, ANGLE_LIMIT);
        o_elb  = to_out(elb, ANGLE_LIMIT);
        o_wri  = to_out(wri, ANGLE_LIMIT);
        if (r_c1.reach) begin
            n_res.reach = 1'b1;
            n_res.base  = o_base[BASE_W-1:0];
            n_res.sho   = o_sho[ANG_W-1:0];
            n_res.elb   = o_elb[ANG_W-1:0];
            n_res.wri   = o_wri[ANG_W-1:0];
        end else begin
            n_res = '0;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage
    logic    inc;
    logic    r_out_vld;
    logic    r_skd_vld;
    t_result r_out;
    t_result r_skd;

    assign en  = !r_skd_vld;
    assign inc = en && r_c1.vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (!r_out_vld || i_m_tready) begin
            if (r_skd_vld) begin
                r_out_vld <= 1'b1;
                r_skd_vld <= 1'b0;
            end else begin
                r_out_vld <= inc;
            end
        end else if (inc) begin
            r_skd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_m_tready) begin
            r_out <= r_skd_vld ? r_skd : n_res;
        end else if (inc) begin
            r_skd <= n_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_out.wri, r_out.elb, r_out.sho, r_out.base};
    assign o_m_tuser  = r_out.reach;

endmodule

// ----- verif/tb_arm_inverse_kinematics.sv -----
// Self-checking testbench for arm_inverse_kinematics: streams targets, predicts each result.
// Depends on aik_pkg and the arm_inverse_kinematics RTL only.
`timescale 1ns / 100ps

module tb_arm_inverse_kinematics;
    import aik_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int END_WAIT   = 120;
    localparam int RAND_ITEMS = 256;

    typedef struct packed {
        logic signed [BASE_W-1:0] base;
        logic signed [ANG_W-1:0]  shoulder;
        logic signed [ANG_W-1:0]  elbow;
        logic signed [ANG_W-1:0]  wrist;
        logic                     reach;
    } t_joints;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        bit                        typed;
        t_joints                   joints;
    } t_target_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tuser;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [LEN_W-1:0]      i_cfg_wdata;

    logic [LEN_W-1:0] arm_regs [NUM_REGS];
    t_joints          joints_due [$];
    int               mismatches;
    int               idle_cycles;
    int               burst_left;
    int               stall_mode;
    int               stall_len;
    bit               s_rdy_q;
    bit               m_fire_q;

    arm_inverse_kinematics u_top (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Floor square root, digit by digit
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // CORDIC vectoring: angle of (a, b) in 1/65536 degree
    function automatic longint heading(longint b, longint a);
        longint z;
        longint da;
        longint db;
        z = 0;
        if (a == 0 && b == 0) return 0;
        a = a * (64'sd1 <<< CORDIC_PRESCALE);
        b = b * (64'sd1 <<< CORDIC_PRESCALE);
        if (a < 0) begin
            z = (b >= 0) ? (64'sd180 <<< ANG_FRAC) : -(64'sd180 <<< ANG_FRAC);
            a = -a;
            b = -b;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0) begin
                a = a + da; b = b - db; z = z + longint'(ATAN_TAB[i]);
            end else begin
                a = a - da; b = b + db; z = z - longint'(ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    // Round half up to 1/256 degree, then saturate
    function automatic longint round_sat(longint v, longint lim);
        v = (v + 128) >>> 8;
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint unsigned pos(longint v);
        return (v < 0) ? 0 : longint'(v);
    endfunction

    // Joint angles for one target under the current arm geometry
    function automatic t_joints solve_joints(logic signed [COORD_W-1:0] tx,
                                             logic signed [COORD_W-1:0] ty,
                                             logic signed [COORD_W-1:0] tz);
        longint x, y, z, side, l1, l2, lsum, ldif, w, sh, ash, h, ra, rb, e, sho;
        longint unsigned hsq;
        t_joints r;
        x    = tx;
        y    = ty;
        z    = tz;
        side = longint'($signed(arm_regs[REG_GRIP_SIDE]));
        l1   = longint'(arm_regs[REG_UPPER_ARM]) <<< LEN_FRAC;
        l2   = longint'(arm_regs[REG_FOREARM]) <<< LEN_FRAC;
        lsum = l1 + l2;
        ldif = (l1 > l2) ? l1 - l2 : l2 - l1;
        r    = '0;
        w = longint'(floor_root(longint'(x * x + y * y + side * side) << (2 * LEN_FRAC)));
        w = w - ((longint'(arm_regs[REG_SHOULDER_FWD]) + longint'(arm_regs[REG_GRIP_FWD]))
                 <<< LEN_FRAC);
        if (w < 0) w = 0;
        sh  = z + longint'(arm_regs[REG_WRIST_DROP]) + longint'(arm_regs[REG_GRIP_H])
              - longint'(arm_regs[REG_SHOULDER_H]);
        ash = ((sh < 0) ? -sh : sh) <<< LEN_FRAC;
        hsq = longint'(w * w) + longint'(ash * ash);
        if (hsq > longint'(lsum * lsum) || hsq < longint'(ldif * ldif)) return r;
        h  = longint'(floor_root(hsq));
        ra = 2 * heading(longint'(floor_root(pos(l2 - l1 + h) * pos(lsum - h))),
                         longint'(floor_root(pos(l1 + h - l2) * pos(lsum + h))));
        rb = heading(ash, w);
        sho = (sh > 0) ? (64'sd90 <<< ANG_FRAC) - (ra + rb) : (64'sd90 <<< ANG_FRAC) - (ra - rb);
        e  = 2 * heading(longint'(floor_root(pos(h - l1 + l2) * pos(h + l1 - l2))),
                         longint'(floor_root(pos(lsum - h) * pos(lsum + h))));
        r.base     = BASE_W'(round_sat(heading(x, y), 46080));
        r.shoulder = ANG_W'(round_sat(sho, 92160));
        r.elbow    = ANG_W'(round_sat((64'sd90 <<< ANG_FRAC) - e, 92160));
        r.wrist    = ANG_W'(round_sat(e - sho - (64'sd90 <<< ANG_FRAC), 92160));
        r.reach    = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    // Write one geometry register; caller guarantees the pipeline is empty
    // and drops the write enable after the last write
    task automatic write_reg(t_reg_idx idx, logic [LEN_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        arm_regs[idx] = val;
    endtask

    // Drop valid and hold until every pending result has come back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (joints_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Offer one request, wait for the handshake, then maybe open a gap
    task automatic send_target(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                               logic signed [COORD_W-1:0] z, bit typed, t_joints want);
        bit rdy;
        t_joints pred;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'd0, z, y, x};
        do begin
            @(negedge i_clk);
            rdy = o_s_tready;
            @(posedge i_clk);
        end while (!rdy);
        pred = solve_joints(x, y, z);
        if (typed && pred != want)
            $display("%0t: table row disagrees with predictor for (%0d,%0d,%0d)",
                     $time, x, y, z);
        joints_due.push_back(typed ? want : pred);
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Mostly targets near the reachable shell, the rest anywhere
    task automatic random_targets(int count, bit hold_midway);
        int span;
        logic signed [COORD_W-1:0] x, y, z;
        for (int n = 0; n < count; n++) begin
            span = int'(arm_regs[REG_UPPER_ARM]) + int'(arm_regs[REG_FOREARM])
                   + int'(arm_regs[REG_SHOULDER_FWD]) + int'(arm_regs[REG_GRIP_FWD]) + 64;
            if (span > 65535) span = 65535;
            if ($urandom_range(0, 9) < 7) begin
                x = COORD_W'(int'($urandom_range(0, 2 * span)) - span);
                y = COORD_W'(int'($urandom_range(0, 2 * span)) - span);
                z = COORD_W'(int'($urandom_range(0, 2 * span)) - span
                             - int'(arm_regs[REG_WRIST_DROP]) - int'(arm_regs[REG_GRIP_H])
                             + int'(arm_regs[REG_SHOULDER_H]));
            end else begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
                z = COORD_W'($urandom);
            end
            send_target(x, y, z, 1'b0, '0);
            if (hold_midway && n == count / 2) drain();
        end
    endtask

    task automatic load_geometry(logic [LEN_W-1:0] g [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++) write_reg(t_reg_idx'(i), g[i]);
        i_cfg_we <= 1'b0;
    endtask

    // Receiver stall pattern: long free stretches, light and heavy stalls
    always @(posedge i_clk) begin
        if (stall_len == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_len  <= $urandom_range(20, 300);
        end else begin
            stall_len <= stall_len - 1;
        end
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= ($urandom_range(0, 3) != 0);
            default: i_m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Check each result the receiver takes against the oldest expectation
    always @(negedge i_clk) begin
        t_joints got;
        t_joints want;
        s_rdy_q  = i_s_tvalid && o_s_tready;
        m_fire_q = o_m_tvalid && i_m_tready;
        if (i_rst_n && m_fire_q) begin
            got = {o_m_tdata[16:0], o_m_tdata[34:17], o_m_tdata[52:35], o_m_tdata[70:53],
                   o_m_tuser};
            if (joints_due.size() == 0) begin
                $display("%0t: result with nothing expected", $time);
                mismatches++;
            end else begin
                want = joints_due.pop_front();
                if (got.base != want.base) report_mismatch("base", got.base, want.base);
                if (got.shoulder != want.shoulder)
                    report_mismatch("shoulder", got.shoulder, want.shoulder);
                if (got.elbow != want.elbow) report_mismatch("elbow", got.elbow, want.elbow);
                if (got.wrist != want.wrist) report_mismatch("wrist", got.wrist, want.wrist);
                if (got.reach != want.reach) report_mismatch("reachable", got.reach, want.reach);
            end
        end
    end

    // Watchdog on cycles with no request moving on either side
    always @(posedge i_clk) begin
        if (s_rdy_q || m_fire_q) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_arm_inverse_kinematics failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_target_row     rows [$];
        logic [LEN_W-1:0] g [NUM_REGS];
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b1;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        mismatches  = 0;
        idle_cycles = 0;
        burst_left  = 0;
        stall_mode  = 0;
        stall_len   = 0;
        s_rdy_q     = 0;
        m_fire_q    = 0;
        arm_regs    = '{16'd1600, 16'd1600, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed targets under the reset geometry
        rows = '{
            '{17'sd0, 17'sd0, 17'sd0, 1'b0, '0},
            '{17'sd65535, 17'sd65535, 17'sd65535, 1'b1, '0},
            '{-17'sd65536, -17'sd65536, -17'sd65536, 1'b1, '0},
            '{17'sd65535, 17'sd0, 17'sd0, 1'b1, '0},
            '{17'sd0, -17'sd65536, 17'sd0, 1'b1, '0},
            '{17'sd0, 17'sd0, 17'sd65535, 1'b1, '0},
            '{17'sd0, 17'sd3201, 17'sd0, 1'b1, '0},
            '{17'sd0, 17'sd3200, 17'sd0, 1'b0, '0},
            '{17'sd0, 17'sd0, 17'sd3200, 1'b0, '0},
            '{17'sd0, 17'sd0, -17'sd3200, 1'b0, '0},
            '{-17'sd1000, -17'sd1000, 17'sd0, 1'b0, '0},
            '{17'sd1000, -17'sd1, 17'sd300, 1'b0, '0},
            '{17'sd0, -17'sd2000, 17'sd500, 1'b0, '0},
            '{17'sd1, 17'sd0, -17'sd1, 1'b0, '0},
            '{-17'sd1200, 17'sd1500, -17'sd900, 1'b0, '0},
            '{17'sd2262, 17'sd2262, 17'sd0, 1'b0, '0}
        };
        foreach (rows[i]) send_target(rows[i].x, rows[i].y, rows[i].z, rows[i].typed,
                                      rows[i].joints);
        random_targets(RAND_ITEMS, 1'b1);

        // Offsets on every register, negative side offset
        drain();
        g = '{16'd2000, 16'd1200, 16'd300, 16'd500, 16'd200, 16'd150, 16'hFE70, 16'd100};
        load_geometry(g);
        random_targets(RAND_ITEMS, 1'b0);

        // Zero-length links
        drain();
        g = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        load_geometry(g);
        send_target(17'sd0, 17'sd0, 17'sd0, 1'b0, '0);
        send_target(17'sd5, 17'sd0, 17'sd0, 1'b1, '0);
        random_targets(RAND_ITEMS / 2, 1'b0);

        // Largest registers, most negative side offset
        drain();
        g = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF};
        load_geometry(g);
        random_targets(RAND_ITEMS / 2, 1'b0);

        // Unequal links, largest positive side offset
        drain();
        g = '{16'd1000, 16'd3000, 16'd40, 16'd900, 16'd0, 16'd700, 16'h7FFF, 16'd0};
        load_geometry(g);
        random_targets(RAND_ITEMS, 1'b0);

        // Random geometries
        for (int p = 0; p < 2; p++) begin
            drain();
            foreach (g[i]) g[i] = (i < 2) ? LEN_W'($urandom_range(0, 20000)) : LEN_W'($urandom);
            load_geometry(g);
            random_targets(RAND_ITEMS, 1'b0);
        end

        drain();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatches == 0 && joints_due.size() == 0) begin
            $display("tb_arm_inverse_kinematics passed");
        end else begin
            $display("tb_arm_inverse_kinematics failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/aik_pkg.sv
sv/aik_sqrt_cell.sv
sv/aik_sqrt.sv
sv/aik_cordic_cell.sv
sv/aik_cordic.sv
sv/arm_inverse_kinematics.sv
verif/tb_arm_inverse_kinematics.sv
